// File: hdl/sadc_pkg.sv
// shared types, constants and the channel decode for the serial converter reader
// no dependencies
package sadc_pkg;

  localparam int DataBitsDef     = 12;
  localparam int JustifyShiftDef = 4;
  localparam int CmdBits         = 5;
  localparam int SampleW         = 16;
  localparam int CodeW           = 8;
  localparam int HalfW           = 8;

  localparam logic [HalfW-1:0] HalfPeriodReset = 8'd49;
  localparam logic [CodeW-1:0] CodeLastDigit   = 8'd3;
  localparam logic [CodeW-1:0] CharLowerA      = 8'd97;
  localparam logic [CodeW-1:0] CharLowerD      = 8'd100;
  localparam logic [CodeW-1:0] CharUpperA      = 8'd65;
  localparam logic [CodeW-1:0] CharUpperD      = 8'd68;

  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CodeW-1:0] channel_code;
    logic             left_justify;
    logic             miso_level;
  } item_t;

  typedef struct packed {
    logic               serial_clock;
    logic               mosi_level;
    logic               chip_select_n;
    logic               busy_res;
    logic               done_res;
    logic [SampleW-1:0] sample_value;
  } result_t;

  function automatic logic [1:0] channel_of(input logic [CodeW-1:0] code);
    logic [1:0] ch;
    ch = 2'd0;
    if (code <= CodeLastDigit) begin
      ch = code[1:0];
    end else if (code >= CharLowerA && code <= CharLowerD) begin
      ch = 2'(code - CharLowerA);
    end else if (code >= CharUpperA && code <= CharUpperD) begin
      ch = 2'(code - CharUpperA);
    end
    return ch;
  endfunction

endpackage

// File: hdl/spi_adc_conversion_reader.sv
// top level of the serial converter reader: input register and update engine
// depends on sadc_pkg, sadc_in_stage, sadc_engine
//
// usage:
//   input (in_valid_i / in_stall_o) takes one beat per unstalled cycle: a tick
//   (op 0) or a start (op 1) with channel code, justify flag and the miso level
//   output channel (out_valid_o / out_stall_i) gives one result beat per input
//   beat: line levels for sclk, mosi and chip select, busy, done and the sample
//   config channel (cfg_valid_i / cfg_ready_o) writes the half period in ticks;
//   a zero acts as one, reset value is 49
//   accepted beats pass the input register, then the result register; one
//   beat per unstalled cycle, the transfer state being updated once per beat
//   a conversion spans 2 * half period * 19 tick beats after its start beat
//   reset returns the transfer to idle, so results show chip select high
//   when out_stall_i holds, the result register keeps its beat and the input
//   register absorbs one more beat, if empty, before in_stall_o rises
module spi_adc_conversion_reader import sadc_pkg::*; #(
  parameter int DATA_BITS     = DataBitsDef,
  parameter int JUSTIFY_SHIFT = JustifyShiftDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [HalfW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [CodeW-1:0]   channel_code_i,
  input  logic               left_justify_i,
  input  logic               miso_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               serial_clock_o,
  output logic               mosi_level_o,
  output logic               chip_select_n_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [SampleW-1:0] sample_value_o
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;

  assign in_item.op           = op_i;
  assign in_item.channel_code = channel_code_i;
  assign in_item.left_justify = left_justify_i;
  assign in_item.miso_level   = miso_level_i;

  sadc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sadc_engine #(
    .DATA_BITS     (DATA_BITS),
    .JUSTIFY_SHIFT (JUSTIFY_SHIFT)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign serial_clock_o  = result.serial_clock;
  assign mosi_level_o    = result.mosi_level;
  assign chip_select_n_o = result.chip_select_n;
  assign busy_res_o      = result.busy_res;
  assign done_res_o      = result.done_res;
  assign sample_value_o  = result.sample_value;

  a_done_ends_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> chip_select_n_o && !busy_res_o)
    else $error("done beat with transfer still active");

  a_cs_tracks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chip_select_n_o != busy_res_o))
    else $error("chip select disagrees with busy");

  a_sample_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> (sample_value_o == '0))
    else $error("sample value outside a done beat");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

// File: hdl/sadc_in_stage.sv
// input register of the converter reader: holds one accepted beat
// depends on sadc_pkg
module sadc_in_stage import sadc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  input  logic  advance_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take, load;

  assign take       = valid_q && advance_i;
  assign load       = in_valid_i && (!valid_q || take);
  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hdl/sadc_engine.sv
// transfer state, one-step update per beat and the result register
// depends on sadc_pkg
module sadc_engine import sadc_pkg::*; #(
  parameter int DATA_BITS     = DataBitsDef,
  parameter int JUSTIFY_SHIFT = JustifyShiftDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [HalfW-1:0] cfg_data_i,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output result_t          result_o
);

  localparam int NullPeriod = CmdBits + 1;
  localparam int LastPeriod = NullPeriod + DATA_BITS + 1;
  localparam int PhaseW     = $clog2(LastPeriod + 1);
  localparam int RxW        = DATA_BITS + 1;

  logic [HalfW-1:0]   hp_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [HalfW-1:0]   cnt_q, cnt_d;
  logic               clk_lvl_q, clk_lvl_d;
  logic [RxW-1:0]     rx_q, rx_d;
  logic [CmdBits-1:0] cmd_q, cmd_d;
  logic               just_q, just_d;
  logic               busy_q, busy_d;
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               fire;
  logic [HalfW-1:0]   hp_eff;
  logic [HalfW-1:0]   cnt_inc;
  logic [31:0]        wide;
  logic [2:0]         cmd_idx;

  assign advance_o   = !out_valid_q || !out_stall_i;
  assign fire        = item_valid_i && advance_o;
  assign cfg_ready_o = !item_valid_i;
  assign hp_eff      = (hp_q == '0) ? HalfW'(1) : hp_q;
  assign cnt_inc     = cnt_q + HalfW'(1);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    clk_lvl_d = clk_lvl_q;
    rx_d      = rx_q;
    cmd_d     = cmd_q;
    just_d    = just_q;
    busy_d    = busy_q;
    res_d     = '0;
    wide      = '0;
    if (item_i.op == OpStart) begin
      if (!busy_q) begin
        busy_d    = 1'b1;
        phase_d   = PhaseW'(1);
        cnt_d     = '0;
        clk_lvl_d = 1'b0;
        rx_d      = '0;
        cmd_d     = {1'b1, 1'b1, 1'b0, channel_of(item_i.channel_code)};
        just_d    = item_i.left_justify;
      end
    end else if (busy_q) begin
      cnt_d = cnt_inc;
      if (cnt_inc >= hp_eff) begin
        cnt_d = '0;
        if (!clk_lvl_q) begin
          clk_lvl_d = 1'b1;
          if (phase_q > PhaseW'(NullPeriod)) begin
            rx_d = {rx_q[RxW-2:0], item_i.miso_level};
          end
        end else begin
          clk_lvl_d = 1'b0;
          if (phase_q >= PhaseW'(LastPeriod)) begin
            wide = 32'(rx_q[DATA_BITS-1:0]);
            if (just_q) begin
              wide = wide << JUSTIFY_SHIFT;
            end
            res_d.done_res     = 1'b1;
            res_d.sample_value = wide[SampleW-1:0];
            busy_d             = 1'b0;
            phase_d            = '0;
          end else begin
            phase_d = phase_q + PhaseW'(1);
          end
        end
      end
    end
    cmd_idx             = 3'(PhaseW'(CmdBits) - phase_d);
    res_d.serial_clock  = clk_lvl_d;
    res_d.mosi_level    = busy_d && (phase_d >= PhaseW'(1)) && (phase_d <= PhaseW'(CmdBits))
                          && cmd_d[cmd_idx];
    res_d.chip_select_n = !busy_d;
    res_d.busy_res      = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= HalfPeriodReset;
      phase_q     <= '0;
      cnt_q       <= '0;
      clk_lvl_q   <= 1'b0;
      rx_q        <= '0;
      cmd_q       <= '0;
      just_q      <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        hp_q <= cfg_data_i;
      end
      if (fire) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        clk_lvl_q   <= clk_lvl_d;
        rx_q        <= rx_d;
        cmd_q       <= cmd_d;
        just_q      <= just_d;
        busy_q      <= busy_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule
